// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the telemetry frame receiver checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ETFR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("etfr assertion failed");

// Condition in one cycle that requires a consequence in the next cycle.
`define ETFR_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("etfr assertion failed");

`endif

// File: design/etfr_pkg.sv
// ----------------------------------------------------------------------------
// etfr_pkg
// Types and constants shared by the frame receiver modules, and the front's CRC-8 step.
// ----------------------------------------------------------------------------
package etfr_pkg;

  localparam int unsigned PAYLOAD_BYTES     = 9;
  localparam int unsigned POS_W             = 4;
  localparam logic [7:0]  CRC_POLY          = 8'h07;
  localparam logic [23:0] GAP_LIMIT_RESET   = 24'd3000;
  localparam int unsigned QUEUE_DEPTH_DFLT  = 2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic        crc_ok;
    logic [7:0]  temperature;
    logic [19:0] bus_voltage;
    logic [19:0] motor_current;
    logic [15:0] charge_mah;
    logic [22:0] erpm;
  } out_item_t;

  // A completed frame as the front hands it to the back: raw big-endian pairs.
  typedef struct packed {
    logic        crc_ok;
    logic [7:0]  temperature;
    logic [15:0] voltage_raw;
    logic [15:0] current_raw;
    logic [15:0] charge_raw;
    logic [15:0] erpm_raw;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] v;
    v = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

// File: design/etfr_front.sv
// ----------------------------------------------------------------------------
// etfr_front
// Frame tracking: gap detection, byte position, running CRC and byte store.
// ----------------------------------------------------------------------------
module etfr_front import etfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_accept,
  input  in_item_t    in_data,
  input  logic [23:0] gap_limit,
  output logic        q_push,
  output frame_t      q_data
);

  logic                 seen_r, seen_nxt;
  logic [31:0]          prev_time_r, prev_time_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [7:0]           crc_r, crc_nxt;
  logic [7:0]           store_r [PAYLOAD_BYTES];

  logic [31:0]          gap;
  logic                 restart;
  logic [POS_W-1:0]     pos_eff;
  logic [7:0]           crc_eff;
  logic                 last_byte;

  assign gap       = in_data.time_us - prev_time_r;
  assign restart   = !seen_r || (gap > {8'd0, gap_limit});
  assign pos_eff   = restart ? '0 : pos_r;
  assign crc_eff   = restart ? '0 : crc_r;
  assign last_byte = (pos_eff == POS_W'(PAYLOAD_BYTES));

  always_comb begin
    seen_nxt      = seen_r;
    prev_time_nxt = prev_time_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    if (in_accept) begin
      seen_nxt      = 1'b1;
      prev_time_nxt = in_data.time_us;
      if (last_byte) begin
        pos_nxt = '0;
        crc_nxt = '0;
      end else begin
        pos_nxt = pos_eff + POS_W'(1);
        crc_nxt = crc8_step(crc_eff, in_data.data_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      prev_time_r <= '0;
      pos_r       <= '0;
      crc_r       <= '0;
    end else begin
      seen_r      <= seen_nxt;
      prev_time_r <= prev_time_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (in_accept && !last_byte && pos_eff == POS_W'(i)) begin
        store_r[i] <= in_data.data_byte;
      end
    end
  end

  assign q_push             = in_accept && last_byte;
  assign q_data.crc_ok      = (crc_eff == in_data.data_byte);
  assign q_data.temperature = store_r[0];
  assign q_data.voltage_raw = {store_r[1], store_r[2]};
  assign q_data.current_raw = {store_r[3], store_r[4]};
  assign q_data.charge_raw  = {store_r[5], store_r[6]};
  assign q_data.erpm_raw    = {store_r[7], store_r[8]};

endmodule

// File: design/etfr_fifo.sv
// ----------------------------------------------------------------------------
// etfr_fifo
// Short queue of completed frames between the front and the back.
// ----------------------------------------------------------------------------
module etfr_fifo import etfr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DFLT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  frame_t    push_data,
  input  logic      pop,
  output frame_t    head,
  output q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frame_t             entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push_en, pop_en;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign push_en      = push && !status.full;
  assign pop_en       = pop && !status.empty;
  assign head         = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_en && !pop_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_en && !push_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/etfr_back.sv
// ----------------------------------------------------------------------------
// etfr_back
// Field scaling and the result output register.
// ----------------------------------------------------------------------------
module etfr_back import etfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  frame_t    q_head,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      load;

  // Constant multiplies are written as shift-and-add.
  function automatic logic [19:0] times_ten(input logic [15:0] x);
    return ({4'd0, x} << 3) + ({4'd0, x} << 1);
  endfunction

  function automatic logic [22:0] times_hundred(input logic [15:0] x);
    return ({7'd0, x} << 6) + ({7'd0, x} << 5) + ({7'd0, x} << 2);
  endfunction

  assign load  = !q_empty && (!out_valid_r || out_pop);
  assign q_pop = load;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt.crc_ok = q_head.crc_ok;
    if (q_head.crc_ok) begin
      out_data_nxt.temperature   = q_head.temperature;
      out_data_nxt.bus_voltage   = times_ten(q_head.voltage_raw);
      out_data_nxt.motor_current = times_ten(q_head.current_raw);
      out_data_nxt.charge_mah    = q_head.charge_raw;
      out_data_nxt.erpm          = times_hundred(q_head.erpm_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/esc_telemetry_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// esc_telemetry_frame_receiver_core
// Ten-byte telemetry frame receiver with CRC-8 check and field decode.
// ----------------------------------------------------------------------------
// The block takes one received byte with its microsecond timestamp per clock
// and never stalls a byte unless the frame queue is full. A frame starts on
// the first byte after reset or when the wrapping time since the previous
// byte is strictly larger than the gap limit. Bytes 0 to 8 are stored and
// folded into a CRC-8 (polynomial 0x07, initial zero, MSB first); the tenth
// byte is compared with that CRC and closes the frame. When its tenth
// request is taken, the closed frame is written into the queue, and from
// there it is loaded into the output register once that is free. Each
// result carries crc_ok and the decoded fields; when the CRC does not match,
// all fields read zero. Results drain at one per cycle while out_pop is
// held high, and QUEUE_DEPTH sets how many finished frames may wait behind
// the output register before full rises. The gap limit resets to 3000 and
// may be rewritten while idle; the configuration channel is always ready.
// ----------------------------------------------------------------------------
module esc_telemetry_frame_receiver_core import etfr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input byte channel.
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_data,
  // Result channel.
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_data,
  // Gap limit write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  logic [23:0] gap_limit_r, gap_limit_nxt;
  logic        in_accept;
  logic        q_push;
  logic        q_pop;
  frame_t      q_in;
  frame_t      q_head;
  q_status_t   q_status;

  // The gap limit write is a single register, so it is always ready.
  assign cfg_ready     = 1'b1;
  assign gap_limit_nxt = (cfg_valid && cfg_ready) ? cfg_data : gap_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= GAP_LIMIT_RESET;
    end else begin
      gap_limit_r <= gap_limit_nxt;
    end
  end

  // Only the tenth byte of a frame writes the queue, but full is kept
  // independent of the payload so the handshake never looks at data.
  assign in_full   = q_status.full;
  assign in_accept = in_push && !in_full;

  etfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .gap_limit (gap_limit_r),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  etfr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  etfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_status.empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

// File: design/etfr_checker.sv
// ----------------------------------------------------------------------------
// etfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module etfr_checker import etfr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_full,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_data
);

  logic fields_zero;
  logic scale_ok;

  assign fields_zero = (out_data.temperature == 8'd0) && (out_data.bus_voltage == 20'd0)
                    && (out_data.motor_current == 20'd0) && (out_data.charge_mah == 16'd0)
                    && (out_data.erpm == 23'd0);
  assign scale_ok    = (out_data.bus_voltage[0] == 1'b0) && (out_data.motor_current[0] == 1'b0)
                    && (out_data.erpm[1:0] == 2'b00);

  // A waiting result that is not taken stays put.
  `ETFR_ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_data))

  // A failed CRC never leaks frame contents.
  `ETFR_ASSERT(a_bad_crc_zero, clk, rst_n, out_empty || out_data.crc_ok || fields_zero)

  // Scaled fields keep the factors of their scale.
  `ETFR_ASSERT(a_scale_bits, clk, rst_n, out_empty || scale_ok)

  // The queue fills only behind a held result.
  `ETFR_ASSERT(a_full_has_out, clk, rst_n, !in_full || !out_empty)

endmodule

bind esc_telemetry_frame_receiver_core etfr_checker u_etfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

// File: tb/sv/frame_checker.sv
// ----------------------------------------------------------------------------
// Telemetry frame checker
// Watches the byte, result and gap limit channels of the frame receiver,
// predicts every finished frame and compares each popped result with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package telemetry_tb_pkg;

  import etfr_pkg::CRC_POLY;

  // CRC-8 over one byte, most significant bit first.
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] v;
    v = acc ^ b;
    repeat (8) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

module frame_checker import etfr_pkg::*; import telemetry_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  in_item_t    in_data,
  input  logic        out_empty,
  input  logic        out_pop,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [23:0] cfg_data,
  output logic [31:0] fail_count,
  output logic [31:0] pending_count
);

  logic [23:0] gap_limit;
  logic [3:0]  fill_level;
  logic [7:0]  frame_crc;
  logic [7:0]  held_bytes [PAYLOAD_BYTES];
  logic [31:0] last_time;
  logic        byte_seen;
  out_item_t   frames_due [$];

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : observe
    logic [31:0] elapsed;
    logic [7:0]  b;
    out_item_t   want;
    out_item_t   got;
    if (!rst_n) begin
      fail_count = '0;
      gap_limit  = GAP_LIMIT_RESET;
      fill_level = '0;
      frame_crc  = '0;
      last_time  = '0;
      byte_seen  = 1'b0;
      frames_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        gap_limit = cfg_data;
      end
      if (in_push && !in_full) begin
        b       = in_data.data_byte;
        elapsed = in_data.time_us - last_time;
        if (!byte_seen || elapsed > {8'd0, gap_limit}) begin
          fill_level = '0;
          frame_crc  = '0;
        end
        byte_seen = 1'b1;
        last_time = in_data.time_us;
        if (fill_level < PAYLOAD_BYTES) begin
          held_bytes[fill_level] = b;
          frame_crc  = crc8_fold(frame_crc, b);
          fill_level = fill_level + 4'd1;
        end else begin
          // Tenth byte: the frame closes whether or not the CRC matches.
          want        = '0;
          want.crc_ok = (frame_crc == b);
          if (want.crc_ok) begin
            want.temperature   = held_bytes[0];
            want.bus_voltage   = 20'({16'd0, held_bytes[1], held_bytes[2]} * 32'd10);
            want.motor_current = 20'({16'd0, held_bytes[3], held_bytes[4]} * 32'd10);
            want.charge_mah    = {held_bytes[5], held_bytes[6]};
            want.erpm          = 23'({16'd0, held_bytes[7], held_bytes[8]} * 32'd100);
          end
          frames_due.push_back(want);
          fill_level = '0;
          frame_crc  = '0;
        end
      end
      if (out_pop && !out_empty) begin
        got = out_data;
        if (frames_due.size() == 0) begin
          $error("result popped while no frame was due");
          fail_count++;
        end else begin
          want = frames_due.pop_front();
          check_field("crc_ok", 32'(want.crc_ok), 32'(got.crc_ok));
          check_field("temperature", 32'(want.temperature), 32'(got.temperature));
          check_field("bus_voltage", 32'(want.bus_voltage), 32'(got.bus_voltage));
          check_field("motor_current", 32'(want.motor_current), 32'(got.motor_current));
          check_field("charge_mah", 32'(want.charge_mah), 32'(got.charge_mah));
          check_field("erpm", 32'(want.erpm), 32'(got.erpm));
        end
      end
    end
    pending_count = frames_due.size();
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Feeds timestamped bytes into the telemetry frame receiver, mostly as
// well-formed ten-byte frames with random content, mixed with noise and cut
// frames, under several gap limits, and leaves all checking to the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import etfr_pkg::*; import telemetry_tb_pkg::*; ();

  // The run never legitimately gets close to this; it only catches a hang.
  localparam longint RUN_LIMIT_NS = 5_000_000;
  // How long the result side refuses to pop during the back-pressure test.
  localparam int HOLD_CYCLES = 400;
  // Cycles to wait once nothing is due, so that no result is still in flight.
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 250;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  in_item_t    in_data;
  logic        out_empty;
  logic        out_pop;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_data;

  logic [31:0] mismatches;
  logic [31:0] frames_pending;

  // Stimulus-side view of the block: the gap limit last written and the
  // timestamp of the last byte offered. Both only shape the stimulus.
  logic [23:0] cur_gap;
  logic [31:0] cur_time;
  int          sent;
  bit          idle_on;
  bit          hold_request;

  esc_telemetry_frame_receiver_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  frame_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data       (in_data),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (mismatches),
    .pending_count (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Anything that keeps the run from finishing ends up here.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Time step inside a frame: mostly anywhere up to the limit, and often
  // exactly on it, since a gap equal to the limit must not restart.
  function automatic logic [31:0] step_delta();
    if ($urandom_range(0, 7) == 0) begin
      return {8'd0, cur_gap};
    end
    return $urandom_range(0, cur_gap);
  endfunction

  // Time step that forces a new frame: just over the limit, well over it,
  // or a timestamp that jumps backwards and so reads as a huge gap.
  function automatic logic [31:0] restart_delta();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return {8'd0, cur_gap} + 32'd1 + $urandom_range(0, 3);
      5, 6, 7:       return {8'd0, cur_gap} + 32'd1 + $urandom_range(0, 100000);
      default:       return $urandom | 32'h8000_0000;
    endcase
  endfunction

  // Offers one byte request, after an occasional idle burst, and holds it
  // until the block takes it. Each falling edge sees at most one assignment
  // to in_push, so a request that follows another keeps push high.
  task automatic send_byte(input logic [7:0] b, input logic [31:0] delta);
    in_item_t item;
    int       gap_len;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap_len = $urandom_range(1, 17);
      repeat (gap_len) begin
        @(negedge clk);
        in_push <= 1'b0;
      end
    end
    cur_time       = cur_time + delta;
    item.data_byte = b;
    item.time_us   = cur_time;
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_full);
    sent++;
  endtask

  // A whole frame: nine payload bytes and the CRC byte, which is corrupted
  // on request. The lead delta decides whether the first byte restarts.
  task automatic send_frame(input bit fixed_fill, input logic [7:0] fill,
                            input bit good_crc, input logic [31:0] lead);
    logic [7:0] body [PAYLOAD_BYTES];
    logic [7:0] crc;
    logic [7:0] tail;
    crc = '0;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      body[k] = fixed_fill ? fill : 8'($urandom_range(0, 255));
      crc     = crc8_fold(crc, body[k]);
    end
    tail = good_crc ? crc : crc ^ 8'($urandom_range(1, 255));
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      send_byte(body[k], (k == 0) ? lead : step_delta());
    end
    send_byte(tail, step_delta());
  endtask

  // One chunk of random traffic. Most chunks are aligned frames so that the
  // decode path is exercised; the rest is loose noise or a frame cut short.
  task automatic send_group();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      send_frame($urandom_range(0, 19) == 0, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                 $urandom_range(0, 6) != 0, restart_delta());
    end else if (kind < 85) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 1) ? step_delta() : $urandom);
      end
    end else begin
      n = $urandom_range(1, 9);
      send_byte(8'($urandom_range(0, 255)), restart_delta());
      repeat (n - 1) send_byte(8'($urandom_range(0, 255)), step_delta());
    end
  endtask

  // Drops the byte channel and waits until every finished frame has been
  // popped, then waits out SETTLE_CYCLES so nothing is still in flight.
  task automatic settle_block();
    @(negedge clk);
    in_push <= 1'b0;
    while (frames_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_gap(input logic [23:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_gap = value;
  endtask

  // Result side. Pops most cycles, stalls in random bursts, and on request
  // refuses to pop for a long stretch counted here, so that the queue fills
  // and the byte channel has to stall.
  initial begin : result_sink
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    out_pop    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_pop <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int          target;
    logic [23:0] next_gap;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    cur_gap      = GAP_LIMIT_RESET;
    cur_time     = '0;
    sent         = 0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The first byte after reset opens a frame wherever the timestamp is.
    // This one starts just below the wrap point, so the frame's timestamps
    // roll over, and all payload bytes are at their maximum.
    cur_time = 32'hFFFF_FFF0;
    send_frame(1'b1, 8'hFF, 1'b1, 32'd0);

    // A few loose bytes that leave a frame half-filled.
    repeat (4) send_byte(8'($urandom_range(0, 255)), step_delta());

    // The timestamp steps backwards, which restarts the frame. The bytes
    // after it arrive exactly on the limit, so they stay in one frame; the
    // zero payload with a wrong CRC byte yields a failed, zeroed result.
    for (int k = 0; k <= PAYLOAD_BYTES; k++) begin
      send_byte((k < PAYLOAD_BYTES) ? 8'h00 : 8'hFF,
                (k == 0) ? 32'hFFFF_FFF9 : {8'd0, cur_gap});
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        // The limit only changes while the block is idle.
        settle_block();
        case (p)
          1:       next_gap = 24'd0;
          2:       next_gap = 24'hFF_FFFF;
          3:       next_gap = 24'($urandom_range(1, 64));
          4:       next_gap = 24'($urandom);
          default: next_gap = GAP_LIMIT_RESET;
        endcase
        write_gap(next_gap);
      end
      // The last phase runs with no idling on either side.
      idle_on = (p < PHASES - 1);
      if (p == 0) begin
        // Keep offering frames while the result side holds off, so the
        // block fills up and stalls the byte channel.
        hold_request = 1'b1;
        repeat (8) send_frame(1'b0, 8'h00, 1'b1, restart_delta());
      end
      target = sent + PHASE_ITEMS;
      while (sent < target) send_group();
    end

    settle_block();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
